// File: hdl/mcdc_pkg.sv
// shared types and constants of the pointer click/drag classifier
package mcdc_pkg;

  // raw event kinds on the input channel
  typedef enum logic [1:0] {
    MODE_PRESS   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_DOUBLE  = 2'd2,
    MODE_MOTION  = 2'd3
  } mode_e;

  // synthesized event kinds on the output channel
  typedef enum logic [3:0] {
    KIND_DOWN    = 4'd0,
    KIND_UP      = 4'd1,
    KIND_CLICK   = 4'd2,
    KIND_DBL     = 4'd3,
    KIND_MOTION  = 4'd4,
    KIND_DSTART  = 4'd5,
    KIND_DRAG    = 4'd6,
    KIND_DEND    = 4'd7,
    KIND_CANCEL  = 4'd8
  } kind_e;

  // button codes
  localparam logic [2:0] BTN_NONE  = 3'd0;
  localparam logic [2:0] BTN_LEFT  = 3'd1;
  localparam logic [2:0] BTN_RIGHT = 3'd3;
  localparam logic [2:0] BTN_MAX   = 3'd5;

  // register indexes (paddr[2])
  localparam logic REG_DRAG_THRESHOLD = 1'b0;
  localparam logic REG_MIN_DRAG_TIME  = 1'b1;

  localparam logic [7:0]  DRAG_THRESHOLD_RST = 8'd2;
  localparam logic [15:0] MIN_DRAG_TIME_RST  = 16'd100;

  localparam int unsigned MaxResults = 3;

  // configuration as seen by the classifier
  typedef struct packed {
    logic [7:0]  drag_threshold;
    logic [15:0] min_drag_time;
  } cfg_t;

  // one synthesized event
  typedef struct packed {
    kind_e              kind;
    logic [2:0]         button;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } result_t;

  // all events caused by one input beat
  typedef struct packed {
    logic [1:0]                     last_idx;
    result_t [MaxResults-1:0]       res;
  } bundle_t;

endpackage

// File: hdl/mouse_click_drag_classifier.sv
// top level of the pointer click/drag classifier
//
// input channel: one raw pointer event per beat (mode, button, meta flag,
// position, millisecond time), in_valid_i / in_stall_o.
// output channel: synthesized events (kind, button, position, last flag),
// out_valid_o / out_stall_i; last_o marks the final event of an input beat.
// each input beat yields one to three output beats.
// the front end classifies an event in the cycle it is accepted and writes
// its events into a two-entry queue; the output sequencer emits one event
// per cycle while the output is not stalled; the first event of a beat
// passes through the queue entry and then the output register. the single
// output port, emitting a beat's 1 to 3 events in turn, sets sustained throughput.
// inputs are taken back to back while the queue has room, also while an
// event waits on a stalled output; a full queue raises in_stall_o.
// reset clears the gesture state, press position and time, the queue and
// the output valid; the registers return to threshold 2 and 100 ms.
// registers (apb, pready always high): 0x0 drag threshold, 0x4 min drag time.
module mouse_click_drag_classifier (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [2:0]         button_i,
  input  logic               meta_held_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [31:0]        time_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         kind_o,
  output logic [2:0]         out_button_o,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic               last_o
);
  import mcdc_pkg::*;

  cfg_t    cfg;
  bundle_t bundle;
  bundle_t head;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  logic    take;

  assign in_stall_o = q_full;
  assign take       = in_valid_i && !q_full;

  mcdc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mcdc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .take_i      (take),
    .mode_i      (mode_i),
    .button_i    (button_i),
    .meta_held_i (meta_held_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .time_ms_i   (time_ms_i),
    .bundle_o    (bundle)
  );

  mcdc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take),
    .push_data_i (bundle),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  mcdc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_head_i     (head),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .out_button_o (out_button_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .last_o       (last_o)
  );

endmodule

// File: hdl/mcdc_regs.sv
// apb register file holding drag threshold and minimum drag time
module mcdc_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output mcdc_pkg::cfg_t       cfg_o
);
  import mcdc_pkg::*;

  logic [7:0]  thr_q;
  logic [15:0] min_time_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= DRAG_THRESHOLD_RST;
      min_time_q <= MIN_DRAG_TIME_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_DRAG_THRESHOLD) begin
        thr_q <= pwdata[7:0];
      end else begin
        min_time_q <= pwdata[15:0];
      end
    end
  end

  // read mux
  always_comb begin
    if (paddr[2] == REG_MIN_DRAG_TIME) begin
      prdata = {16'd0, min_time_q};
    end else begin
      prdata = {24'd0, thr_q};
    end
  end

  assign cfg_o.drag_threshold = thr_q;
  assign cfg_o.min_drag_time  = min_time_q;

endmodule

// File: hdl/mcdc_front.sv
// front end: keeps the gesture state and turns each input beat into an event bundle
module mcdc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mcdc_pkg::cfg_t        cfg_i,
  input  logic                  take_i,
  input  logic [1:0]            mode_i,
  input  logic [2:0]            button_i,
  input  logic                  meta_held_i,
  input  logic signed [15:0]    pos_x_i,
  input  logic signed [15:0]    pos_y_i,
  input  logic [31:0]           time_ms_i,
  output mcdc_pkg::bundle_t     bundle_o
);
  import mcdc_pkg::*;

  function automatic result_t mk_res(kind_e k, logic [2:0] b,
                                     logic signed [15:0] x, logic signed [15:0] y);
    result_t r;
    r.kind   = k;
    r.button = b;
    r.x      = x;
    r.y      = y;
    return r;
  endfunction

  logic               dragging_q, dragging_d;
  logic               button_down_q, button_down_d;
  logic               up_right_q, up_right_d;
  logic               up_double_q, up_double_d;
  logic signed [15:0] press_x_q, press_x_d;
  logic signed [15:0] press_y_q, press_y_d;
  logic [31:0]        press_time_q, press_time_d;

  logic [2:0]         btn;
  logic [2:0]         btn_rel;
  logic signed [16:0] dx, dy;
  logic [16:0]        adx, ady;
  logic               beyond;
  logic [31:0]        dur;
  logic               too_short;
  result_t            zero_res;

  // button cleanup and release remap after a meta press
  assign btn     = (button_i > BTN_MAX) ? BTN_NONE : button_i;
  assign btn_rel = (up_right_q && btn == BTN_LEFT) ? BTN_RIGHT : btn;

  // travel from the last press against the threshold, per axis
  assign dx     = {pos_x_i[15], pos_x_i} - {press_x_q[15], press_x_q};
  assign dy     = {pos_y_i[15], pos_y_i} - {press_y_q[15], press_y_q};
  assign adx    = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady    = dy[16] ? 17'(-dy) : 17'(dy);
  assign beyond = (adx > {9'd0, cfg_i.drag_threshold}) ||
                  (ady > {9'd0, cfg_i.drag_threshold});

  // wrapping drag duration
  assign dur       = time_ms_i - press_time_q;
  assign too_short = dur < {16'd0, cfg_i.min_drag_time};

  assign zero_res = mk_res(KIND_CANCEL, BTN_NONE, 16'sd0, 16'sd0);

  // classification and next state
  always_comb begin
    dragging_d    = dragging_q;
    button_down_d = button_down_q;
    up_right_d    = up_right_q;
    up_double_d   = up_double_q;
    press_x_d     = press_x_q;
    press_y_d     = press_y_q;
    press_time_d  = press_time_q;
    bundle_o.last_idx = 2'd0;
    bundle_o.res      = {MaxResults{zero_res}};
    unique case (mode_e'(mode_i))
      MODE_PRESS: begin
        press_x_d     = pos_x_i;
        press_y_d     = pos_y_i;
        press_time_d  = time_ms_i;
        button_down_d = 1'b1;
        if (meta_held_i) begin
          up_right_d = 1'b1;
        end
        bundle_o.res[0] = mk_res(KIND_DOWN, meta_held_i ? BTN_RIGHT : btn,
                                 pos_x_i, pos_y_i);
      end
      MODE_RELEASE: begin
        up_right_d    = 1'b0;
        button_down_d = 1'b0;
        up_double_d   = 1'b0;
        dragging_d    = 1'b0;
        if (dragging_q) begin
          if (too_short) begin
            bundle_o.res[0] = zero_res;
            if (!beyond) begin
              bundle_o.res[1]   = mk_res(KIND_CLICK, btn_rel, press_x_q, press_y_q);
              bundle_o.res[2]   = mk_res(KIND_UP, btn_rel, pos_x_i, pos_y_i);
              bundle_o.last_idx = 2'd2;
            end else begin
              bundle_o.res[1]   = mk_res(KIND_UP, btn_rel, pos_x_i, pos_y_i);
              bundle_o.last_idx = 2'd1;
            end
          end else begin
            bundle_o.res[0]   = mk_res(KIND_DEND, btn_rel, pos_x_i, pos_y_i);
            bundle_o.res[1]   = mk_res(KIND_UP, btn_rel, pos_x_i, pos_y_i);
            bundle_o.last_idx = 2'd1;
          end
        end else if (!up_double_q) begin
          bundle_o.res[0]   = mk_res(KIND_CLICK, btn_rel, press_x_q, press_y_q);
          bundle_o.res[1]   = mk_res(KIND_UP, btn_rel, pos_x_i, pos_y_i);
          bundle_o.last_idx = 2'd1;
        end else begin
          bundle_o.res[0] = mk_res(KIND_UP, btn_rel, pos_x_i, pos_y_i);
        end
      end
      MODE_DOUBLE: begin
        up_double_d       = 1'b1;
        bundle_o.res[0]   = mk_res(KIND_DOWN, btn, pos_x_i, pos_y_i);
        bundle_o.res[1]   = mk_res(KIND_DBL, btn, pos_x_i, pos_y_i);
        bundle_o.last_idx = 2'd1;
      end
      MODE_MOTION: begin
        if (!dragging_q && button_down_q && beyond) begin
          dragging_d        = 1'b1;
          bundle_o.res[0]   = mk_res(KIND_DSTART, btn, press_x_q, press_y_q);
          bundle_o.res[1]   = mk_res(KIND_DRAG, btn, pos_x_i, pos_y_i);
          bundle_o.last_idx = 2'd1;
        end else begin
          bundle_o.res[0] = mk_res(dragging_q ? KIND_DRAG : KIND_MOTION, btn,
                                   pos_x_i, pos_y_i);
        end
      end
      default: begin
        bundle_o.res[0] = zero_res;
      end
    endcase
  end

  // gesture state, updated on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dragging_q    <= 1'b0;
      button_down_q <= 1'b0;
      up_right_q    <= 1'b0;
      up_double_q   <= 1'b0;
      press_x_q     <= 16'sd0;
      press_y_q     <= 16'sd0;
      press_time_q  <= 32'd0;
    end else if (take_i) begin
      dragging_q    <= dragging_d;
      button_down_q <= button_down_d;
      up_right_q    <= up_right_d;
      up_double_q   <= up_double_d;
      press_x_q     <= press_x_d;
      press_y_q     <= press_y_d;
      press_time_q  <= press_time_d;
    end
  end

endmodule

// File: hdl/mcdc_queue.sv
// two-entry bundle queue between front end and output sequencer
module mcdc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mcdc_pkg::bundle_t  push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output mcdc_pkg::bundle_t  head_o
);
  import mcdc_pkg::*;

  bundle_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign head_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// File: hdl/mcdc_back.sv
// output sequencer: emits the events of each bundle one beat at a time
module mcdc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  mcdc_pkg::bundle_t  q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         kind_o,
  output logic [2:0]         out_button_o,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic               last_o
);
  import mcdc_pkg::*;

  logic       out_valid_q;
  logic [1:0] idx_q;
  logic       load;
  logic       at_last;
  result_t    res_q;
  logic       last_q;

  assign load    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign at_last = idx_q == q_head_i.last_idx;
  assign q_pop_o = load && at_last;

  // position within the current bundle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= at_last ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= q_head_i.res[idx_q];
      last_q <= at_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = res_q.kind;
  assign out_button_o = res_q.button;
  assign out_x_o      = res_q.x;
  assign out_y_o      = res_q.y;
  assign last_o       = last_q;

endmodule

// File: dv/tb_top.sv
// self-checking testbench of the pointer click/drag classifier
module tb_top;
  import mcdc_pkg::*;

  localparam int QuietLimit = 4000;
  localparam int TailCycles = 20;

  // one expected output beat
  typedef struct packed {
    result_t ev;
    logic    last;
  } gesture_beat_t;

  // directed stimulus row; n_ev of zero means the row is left to the predictor
  typedef struct packed {
    mode_e       mode;
    logic [2:0]  btn;
    logic        meta;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] t;
    logic [1:0]  n_ev;
    kind_e       kind;
  } dir_row_t;

  localparam dir_row_t DirectedRows [24] = '{
    '{MODE_MOTION,  3'd0, 1'b0, 16'h0000, 16'h0000, 32'd0,     2'd1, KIND_MOTION},
    '{MODE_RELEASE, 3'd1, 1'b0, 16'h0005, 16'h0005, 32'd10,    2'd2, KIND_CLICK},
    '{MODE_PRESS,   3'd7, 1'b0, 16'h7fff, 16'h8000, 32'd20,    2'd1, KIND_DOWN},
    '{MODE_MOTION,  3'd0, 1'b0, 16'h7fff, 16'h8000, 32'd20,    2'd1, KIND_MOTION},
    '{MODE_MOTION,  3'd0, 1'b0, 16'h8000, 16'h7fff, 32'd21,    2'd2, KIND_DSTART},
    '{MODE_RELEASE, 3'd0, 1'b0, 16'h7fff, 16'h8000, 32'd21,    2'd3, KIND_CANCEL},
    '{MODE_PRESS,   3'd1, 1'b1, 16'd100,  16'd100,  32'd1000,  2'd1, KIND_DOWN},
    '{MODE_MOTION,  3'd1, 1'b0, 16'd103,  16'd100,  32'd1001,  2'd2, KIND_DSTART},
    '{MODE_RELEASE, 3'd1, 1'b0, 16'd103,  16'd100,  32'd1050,  2'd2, KIND_CANCEL},
    '{MODE_PRESS,   3'd2, 1'b0, 16'd0,    16'd0,    32'd2000,  2'd0, KIND_DOWN},
    '{MODE_MOTION,  3'd2, 1'b0, 16'd0,    16'd3,    32'd2010,  2'd0, KIND_DOWN},
    '{MODE_MOTION,  3'd2, 1'b0, 16'd0,    16'd50,   32'd2050,  2'd0, KIND_DOWN},
    '{MODE_RELEASE, 3'd2, 1'b0, 16'd0,    16'd50,   32'd2100,  2'd2, KIND_DEND},
    '{MODE_DOUBLE,  3'd1, 1'b0, 16'd10,   16'd10,   32'd2200,  2'd2, KIND_DOWN},
    '{MODE_RELEASE, 3'd1, 1'b0, 16'd10,   16'd10,   32'd2210,  2'd1, KIND_UP},
    '{MODE_PRESS,   3'd5, 1'b0, 16'h8000, 16'h8000, 32'hffffffff, 2'd0, KIND_DOWN},
    '{MODE_MOTION,  3'd5, 1'b0, 16'h8003, 16'h8000, 32'd0,     2'd0, KIND_DOWN},
    '{MODE_RELEASE, 3'd5, 1'b0, 16'h8000, 16'h8000, 32'd10,    2'd3, KIND_CANCEL},
    '{MODE_PRESS,   3'd4, 1'b0, 16'd0,    16'd0,    32'd500,   2'd0, KIND_DOWN},
    '{MODE_MOTION,  3'd4, 1'b0, 16'hfffd, 16'd0,    32'd510,   2'd0, KIND_DOWN},
    '{MODE_RELEASE, 3'd4, 1'b0, 16'd0,    16'd0,    32'd400,   2'd2, KIND_DEND},
    '{MODE_PRESS,   3'd2, 1'b1, 16'd20,   16'd20,   32'd600,   2'd0, KIND_DOWN},
    '{MODE_RELEASE, 3'd2, 1'b0, 16'd20,   16'd20,   32'd610,   2'd0, KIND_DOWN},
    '{MODE_MOTION,  3'd6, 1'b1, 16'h04d2, 16'hfb2e, 32'd700,   2'd1, KIND_MOTION}
  };

  logic               clk_i;
  logic               rst_ni       = 1'b0;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [2:0]         paddr        = '0;
  logic [31:0]        pwdata       = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i       = '0;
  logic [2:0]         button_i     = '0;
  logic               meta_held_i  = 1'b0;
  logic signed [15:0] pos_x_i      = '0;
  logic signed [15:0] pos_y_i      = '0;
  logic [31:0]        time_ms_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [3:0]         kind_o;
  logic [2:0]         out_button_o;
  logic signed [15:0] out_x_o;
  logic signed [15:0] out_y_o;
  logic               last_o;

  mouse_click_drag_classifier i_dut (.*);

  // predictor copy of configuration and gesture state
  logic [7:0]         drag_thresh = DRAG_THRESHOLD_RST;
  logic [15:0]        min_time    = MIN_DRAG_TIME_RST;
  logic               dragging, btn_down, up_is_right, up_is_double;
  logic signed [15:0] press_x, press_y;
  logic [31:0]        press_time;

  gesture_beat_t pending_events [$];
  int unsigned   mismatches   = 0;
  int unsigned   items_sent   = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   tx_idle_pct  = 0;
  int unsigned   rx_stall_pct = 0;
  logic [31:0]   clock_ms;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %s: expected %0h got %0h", what, exp_v, act_v);
    end
  endtask

  function automatic bit beyond_threshold(input logic signed [15:0] x,
                                          input logic signed [15:0] y);
    int dx, dy;
    dx = int'(x) - int'(press_x);
    dy = int'(y) - int'(press_y);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return dx > int'(drag_thresh) || dy > int'(drag_thresh);
  endfunction

  function automatic gesture_beat_t mk_event(input kind_e kind, input logic [2:0] btn,
                                             input logic signed [15:0] x,
                                             input logic signed [15:0] y);
    gesture_beat_t b;
    b.ev.kind   = kind;
    b.ev.button = btn;
    b.ev.x      = x;
    b.ev.y      = y;
    b.last      = 1'b0;
    return b;
  endfunction

  // gesture predictor: updates state and queues the events of one raw event
  function automatic void classify_event(input mode_e mode, input logic [2:0] btn_in,
                                         input logic meta, input logic signed [15:0] x,
                                         input logic signed [15:0] y, input logic [31:0] t,
                                         output int n_ev, output kind_e first_kind);
    gesture_beat_t evs [3];
    logic [2:0]    b;
    logic [31:0]   dur;
    int            n;
    n = 0;
    b = (btn_in > BTN_MAX) ? BTN_NONE : btn_in;
    case (mode)
      MODE_PRESS: begin
        if (meta) begin
          b = BTN_RIGHT;
          up_is_right = 1'b1;
        end
        press_x    = x;
        press_y    = y;
        press_time = t;
        btn_down   = 1'b1;
        evs[n] = mk_event(KIND_DOWN, b, x, y); n++;
      end
      MODE_RELEASE: begin
        if (up_is_right) begin
          up_is_right = 1'b0;
          if (b == BTN_LEFT) b = BTN_RIGHT;
        end
        if (dragging) begin
          dur = t - press_time;
          dragging = 1'b0;
          if (dur < 32'(min_time)) begin
            // accidental drag: cancel, then click if back near the press
            evs[n] = mk_event(KIND_CANCEL, BTN_NONE, '0, '0); n++;
            if (!beyond_threshold(x, y)) begin
              evs[n] = mk_event(KIND_CLICK, b, press_x, press_y); n++;
            end
          end else begin
            evs[n] = mk_event(KIND_DEND, b, x, y); n++;
          end
        end else if (!up_is_double) begin
          evs[n] = mk_event(KIND_CLICK, b, press_x, press_y); n++;
        end
        btn_down     = 1'b0;
        up_is_double = 1'b0;
        evs[n] = mk_event(KIND_UP, b, x, y); n++;
      end
      MODE_DOUBLE: begin
        evs[n] = mk_event(KIND_DOWN, b, x, y); n++;
        evs[n] = mk_event(KIND_DBL, b, x, y); n++;
        up_is_double = 1'b1;
      end
      default: begin
        if (!dragging && btn_down && beyond_threshold(x, y)) begin
          evs[n] = mk_event(KIND_DSTART, b, press_x, press_y); n++;
          dragging = 1'b1;
        end
        evs[n] = mk_event(dragging ? KIND_DRAG : KIND_MOTION, b, x, y); n++;
      end
    endcase
    evs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_events = {pending_events, evs[i]};
    n_ev       = n;
    first_kind = evs[0].ev.kind;
  endfunction

  // drive one input beat and wait until it is taken
  task automatic send_event(input mode_e mode, input logic [2:0] btn, input logic meta,
                            input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic [31:0] t, output int n_ev,
                            output kind_e first_kind);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    button_i    <= btn;
    meta_held_i <= meta;
    pos_x_i     <= x;
    pos_y_i     <= y;
    time_ms_i   <= t;
    do @(posedge clk_i); while (in_stall_o);
    classify_event(mode, btn, meta, x, y, t, n_ev, first_kind);
    items_sent++;
  endtask

  // hold the input side until every queued event has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_DRAG_THRESHOLD) drag_thresh = val[7:0];
    else min_time = val[15:0];
    @(posedge clk_i);
  endtask

  // read back a register and compare with the predictor copy
  task automatic reg_check(input logic idx);
    logic [31:0] exp_v;
    exp_v = (idx == REG_DRAG_THRESHOLD) ? {24'd0, drag_thresh} : {16'd0, min_time};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== exp_v) note_mismatch("register read", exp_v, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] near_press(input logic signed [15:0] c);
    int span;
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    span = int'(drag_thresh) + 3;
    return c + 16'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic logic [31:0] advance_clock_ms();
    clock_ms = clock_ms + 32'($urandom_range(0, 2 * int'(min_time) + 4));
    return clock_ms;
  endfunction

  // one random gesture: mostly press / motion / release, some double clicks, some noise
  task automatic run_gesture();
    int unsigned        pick;
    int                 n_ev;
    kind_e              k;
    logic [2:0]         b, rb;
    logic               meta;
    logic signed [15:0] cx, cy;
    pick = $urandom_range(0, 9);
    b    = 3'($urandom_range(1, 5));
    meta = ($urandom_range(0, 3) == 0);
    cx   = 16'($urandom);
    cy   = 16'($urandom);
    if (pick < 6) begin
      send_event(MODE_PRESS, b, meta, cx, cy, advance_clock_ms(), n_ev, k);
      repeat ($urandom_range(0, 4)) begin
        send_event(MODE_MOTION, b, 1'($urandom_range(0, 1)), near_press(cx),
                   near_press(cy), advance_clock_ms(), n_ev, k);
      end
      rb = b;
      if (meta && $urandom_range(0, 1) == 1) rb = BTN_LEFT;
      if ($urandom_range(0, 4) == 0) rb = 3'($urandom_range(0, 7));
      send_event(MODE_RELEASE, rb, 1'b0, near_press(cx), near_press(cy),
                 advance_clock_ms(), n_ev, k);
    end else if (pick < 8) begin
      send_event(MODE_PRESS, b, meta, cx, cy, advance_clock_ms(), n_ev, k);
      send_event(MODE_RELEASE, b, 1'b0, cx, cy, advance_clock_ms(), n_ev, k);
      send_event(MODE_DOUBLE, b, 1'b0, cx, cy, advance_clock_ms(), n_ev, k);
      if ($urandom_range(0, 2) == 0) begin
        send_event(MODE_MOTION, b, 1'b0, near_press(cx), near_press(cy),
                   advance_clock_ms(), n_ev, k);
      end
      send_event(MODE_RELEASE, b, 1'b0, near_press(cx), near_press(cy),
                 advance_clock_ms(), n_ev, k);
    end else begin
      repeat ($urandom_range(1, 3)) begin
        send_event(mode_e'(2'($urandom_range(0, 3))), 3'($urandom_range(0, 7)),
                   1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                   $urandom, n_ev, k);
      end
    end
  endtask

  // settle, reprogram, then run random gestures
  task automatic run_phase(input logic [7:0] thr, input logic [15:0] min_ms,
                           input int unsigned tx_pct, input int unsigned rx_pct,
                           input int unsigned n_items);
    int unsigned target;
    drain_results();
    repeat (4) @(posedge clk_i);
    reg_write(REG_DRAG_THRESHOLD, {24'd0, thr});
    reg_write(REG_MIN_DRAG_TIME, {16'd0, min_ms});
    reg_check(REG_DRAG_THRESHOLD);
    reg_check(REG_MIN_DRAG_TIME);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    clock_ms     = $urandom;
    target       = items_sent + n_items;
    while (items_sent < target) begin
      run_gesture();
      if ($urandom_range(0, 29) == 0) drain_results();
    end
  endtask

  // output side: random stall and event check
  always @(posedge clk_i) begin
    gesture_beat_t e;
    if (out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        note_mismatch("event with none expected", 32'd0, {28'd0, kind_o});
      end else begin
        e = pending_events.pop_front();
        if (kind_o !== e.ev.kind) note_mismatch("kind", 32'(e.ev.kind), 32'(kind_o));
        if (out_button_o !== e.ev.button) begin
          note_mismatch("button", 32'(e.ev.button), 32'(out_button_o));
        end
        if (out_x_o !== e.ev.x) note_mismatch("x", 32'(e.ev.x), 32'(out_x_o));
        if (out_y_o !== e.ev.y) note_mismatch("y", 32'(e.ev.y), 32'(out_y_o));
        if (last_o !== e.last) note_mismatch("last", 32'(e.last), 32'(last_o));
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
  end

  // watchdog on beats moving through either port or on register accesses
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence
  initial begin
    int    n_ev;
    kind_e k;
    dir_row_t row;
    dragging     = 1'b0;
    btn_down     = 1'b0;
    up_is_right  = 1'b0;
    up_is_double = 1'b0;
    press_x      = '0;
    press_y      = '0;
    press_time   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers hold their reset values
    reg_check(REG_DRAG_THRESHOLD);
    reg_check(REG_MIN_DRAG_TIME);

    // directed rows with the reset configuration
    tx_idle_pct  = 19;
    rx_stall_pct = 75;
    for (int i = 0; i < 24; i++) begin
      row = DirectedRows[i];
      send_event(row.mode, row.btn, row.meta, row.x, row.y, row.t, n_ev, k);
      if (row.n_ev != 0) begin
        if (n_ev != int'(row.n_ev)) begin
          note_mismatch("directed event count", 32'(row.n_ev), 32'(n_ev));
        end
        if (k != row.kind) note_mismatch("directed first kind", 32'(row.kind), 32'(k));
      end
    end

    run_phase(8'd0, 16'd0, 19, 75, 90);
    run_phase(8'd255, 16'hffff, 75, 19, 90);
    run_phase(8'($urandom_range(1, 254)), 16'($urandom_range(1, 1000)), 75, 19, 60);
    run_phase(8'($urandom_range(0, 8)), 16'($urandom_range(0, 300)), 0, 0, 90);

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (pending_events.size() != 0) begin
      note_mismatch("events never produced", 32'(pending_events.size()), 32'd0);
    end
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
